// File: design/graph_traversal_adjacency_macros.svh
// assertion macros for the graph traversal block
`ifndef GRAPH_TRAVERSAL_ADJACENCY_MACROS_SVH
`define GRAPH_TRAVERSAL_ADJACENCY_MACROS_SVH

`ifndef SYNTHESIS
`define GTA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("graph traversal check failed");
`define GTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("graph traversal check failed");
`else
`define GTA_ASSERT_SAME(lbl, ante, cons)
`define GTA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/gta_pkg.sv
`timescale 1ns / 1ps
package gta_pkg;

	localparam int VERT_W    = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_ORDER = 2'd2;

	localparam logic REQ_EDGE     = 1'b0;
	localparam logic REQ_TRAVERSE = 1'b1;

	localparam logic ORDER_DFS = 1'b0;
	localparam logic ORDER_BFS = 1'b1;

	localparam logic [VERT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

	typedef struct packed {
		logic              req_type;
		logic [VERT_W-1:0] src_vertex;
		logic [VERT_W-1:0] dst_vertex;
		logic [VERT_W-1:0] start_vertex;
	} gta_in_t;

	typedef struct packed {
		logic [VERT_W-1:0] vertex;
		logic              last;
	} gta_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE_RD_SRC,
		ST_EDGE_WR_SRC,
		ST_EDGE_RD_DST,
		ST_EDGE_WR_DST,
		ST_DFS_TOP,
		ST_DFS_ROW,
		ST_DFS_PICK,
		ST_BFS_DEQ,
		ST_BFS_ROW,
		ST_BFS_SCAN,
		ST_FINISH
	} gta_state_t;

endpackage

// File: design/graph_traversal_adjacency.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------
// in        | in        | in_valid / in_stall  | gta_in_t: edge or traversal request
// out       | out       | out_valid / out_stall| gta_out_t: visited vertex, last flag
// cfg       | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// edge request: an invalid one is dropped; a valid one reads and rewrites the source row
//   and, when undirected, then the destination row, via the matrix read and write ports
// traversal: depth first reads the stack top, then its matrix row, then picks unvisited
//   neighbours; breadth first dequeues a vertex, reads its row, then queues unvisited ones
// reset clears the row valid flags at once, so no clearing pass is needed
// out_stall holds the walk when the output register is full; in_stall is high while busy
`timescale 1ns / 1ps
`include "graph_traversal_adjacency_macros.svh"
module graph_traversal_adjacency #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gta_pkg::gta_in_t                    in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gta_pkg::gta_out_t                   out_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gta_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gta_pkg::VERT_W-1:0]          cfg_data
);
	import gta_pkg::*;

	localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CW    = (CNT_W > VERT_W) ? CNT_W : VERT_W;
	localparam logic [CW-1:0] MAX_V = CW'(MAX_VERTICES);
	localparam logic [CW-1:0] ONE_V = CW'(1);

	function automatic logic [IW-1:0] first_set(input logic [MAX_VERTICES-1:0] x);
		logic [IW-1:0] r;
		r = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (x[i]) r = IW'(i);
		end
		return r;
	endfunction

	function automatic logic [MAX_VERTICES-1:0] bit_of(input logic [IW-1:0] idx);
		return {{(MAX_VERTICES-1){1'b0}}, 1'b1} << idx;
	endfunction

	gta_state_t state_q, state_d;

	logic [VERT_W-1:0] vertex_count_q;
	logic              directed_q;
	logic              search_order_q;

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] adj_rd_s1;
	logic                    adj_vld_s1;
	logic [CW-1:0]           wl_mem [MAX_VERTICES];
	logic [CW-1:0]           wl_rd_s1;

	logic [MAX_VERTICES-1:0] visited_q;
	logic [CW-1:0]           head_q, tail_q;
	logic [CW-1:0]           src_q, dst_q, pend_q;
	logic                    out_valid_q;
	gta_out_t                out_item_q;

	logic [CW-1:0]           lim, in_src, in_dst, in_start, tail_m1, cand_vert;
	logic [MAX_VERTICES-1:0] lim_mask, adj_row, cand;
	logic [IW-1:0]           cand_idx;
	logic                    cand_any, out_free, acc, edge_ok, start_ok, bfs_first;

	logic                    adj_rd_en, adj_wr_en, wl_rd_en, wl_wr_en;
	logic [IW-1:0]           adj_rd_addr, adj_wr_addr, wl_rd_addr, wl_wr_addr;
	logic [MAX_VERTICES-1:0] adj_wr_data;
	logic [CW-1:0]           wl_wr_data;
	logic                    emit, emit_last, push, pop, deq, trav_start;

	assign lim       = (CW'(vertex_count_q) > MAX_V) ? MAX_V : CW'(vertex_count_q);
	assign in_src    = CW'(in_item.src_vertex);
	assign in_dst    = CW'(in_item.dst_vertex);
	assign in_start  = CW'(in_item.start_vertex);
	assign edge_ok   = (in_src != '0) && (in_dst != '0) && (in_src <= lim) &&
	                   (in_dst <= lim) && (in_src != in_dst);
	assign start_ok  = (in_start != '0) && (in_start <= lim);
	assign acc       = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign tail_m1   = tail_q - ONE_V;
	assign bfs_first = (head_q == ONE_V);

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			lim_mask[i] = (CW'(i) < lim);
		end
	end

	assign adj_row   = adj_vld_s1 ? adj_rd_s1 : '0;
	assign cand      = adj_row & ~visited_q & lim_mask;
	assign cand_any  = |cand;
	assign cand_idx  = first_set(cand);
	assign cand_vert = CW'(cand_idx) + ONE_V;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_item.req_type == REQ_EDGE) begin
						state_d = edge_ok ? ST_EDGE_RD_SRC : ST_IDLE;
					end else if (!start_ok) begin
						state_d = ST_IDLE;
					end else begin
						state_d = (search_order_q == ORDER_BFS) ? ST_BFS_DEQ : ST_DFS_TOP;
					end
				end
			end
			ST_EDGE_RD_SRC: state_d = ST_EDGE_WR_SRC;
			ST_EDGE_WR_SRC: state_d = directed_q ? ST_IDLE : ST_EDGE_RD_DST;
			ST_EDGE_RD_DST: state_d = ST_EDGE_WR_DST;
			ST_EDGE_WR_DST: state_d = ST_IDLE;
			ST_DFS_TOP:     state_d = (tail_q == '0) ? ST_FINISH : ST_DFS_ROW;
			ST_DFS_ROW:     state_d = ST_DFS_PICK;
			ST_DFS_PICK:    state_d = cand_any ? ST_DFS_PICK : ST_DFS_TOP;
			ST_BFS_DEQ:     state_d = (head_q == tail_q) ? ST_FINISH : ST_BFS_ROW;
			ST_BFS_ROW:     state_d = (bfs_first || out_free) ? ST_BFS_SCAN : ST_BFS_ROW;
			ST_BFS_SCAN:    state_d = cand_any ? ST_BFS_SCAN : ST_BFS_DEQ;
			ST_FINISH:      state_d = out_free ? ST_IDLE : ST_FINISH;
			default:        state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall    = 1'b1;
		adj_rd_en   = 1'b0;
		adj_rd_addr = '0;
		adj_wr_en   = 1'b0;
		adj_wr_addr = '0;
		adj_wr_data = '0;
		wl_rd_en    = 1'b0;
		wl_rd_addr  = '0;
		wl_wr_en    = 1'b0;
		wl_wr_addr  = '0;
		wl_wr_data  = '0;
		emit        = 1'b0;
		emit_last   = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		deq         = 1'b0;
		trav_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (acc && in_item.req_type == REQ_TRAVERSE) begin
					trav_start = 1'b1;
					wl_wr_en   = start_ok;
					wl_wr_data = in_start;
				end
			end
			ST_EDGE_RD_SRC: begin
				adj_rd_en   = 1'b1;
				adj_rd_addr = IW'(src_q - ONE_V);
			end
			ST_EDGE_WR_SRC: begin
				adj_wr_en   = 1'b1;
				adj_wr_addr = IW'(src_q - ONE_V);
				adj_wr_data = adj_row | bit_of(IW'(dst_q - ONE_V));
			end
			ST_EDGE_RD_DST: begin
				adj_rd_en   = 1'b1;
				adj_rd_addr = IW'(dst_q - ONE_V);
			end
			ST_EDGE_WR_DST: begin
				adj_wr_en   = 1'b1;
				adj_wr_addr = IW'(dst_q - ONE_V);
				adj_wr_data = adj_row | bit_of(IW'(src_q - ONE_V));
			end
			ST_DFS_TOP: begin
				wl_rd_en   = (tail_q != '0);
				wl_rd_addr = tail_m1[IW-1:0];
			end
			ST_DFS_ROW: begin
				adj_rd_en   = 1'b1;
				adj_rd_addr = IW'(wl_rd_s1 - ONE_V);
			end
			ST_DFS_PICK: begin
				if (!cand_any) begin
					pop = 1'b1;
				end else if (out_free) begin
					push        = 1'b1;
					emit        = 1'b1;
					adj_rd_en   = 1'b1;
					adj_rd_addr = cand_idx;
					wl_wr_en    = 1'b1;
					wl_wr_addr  = tail_q[IW-1:0];
					wl_wr_data  = cand_vert;
				end
			end
			ST_BFS_DEQ: begin
				deq        = (head_q != tail_q);
				wl_rd_en   = deq;
				wl_rd_addr = head_q[IW-1:0];
			end
			ST_BFS_ROW: begin
				if (bfs_first || out_free) begin
					emit        = !bfs_first;
					adj_rd_en   = 1'b1;
					adj_rd_addr = IW'(wl_rd_s1 - ONE_V);
				end
			end
			ST_BFS_SCAN: begin
				if (cand_any) begin
					push       = 1'b1;
					wl_wr_en   = 1'b1;
					wl_wr_addr = tail_q[IW-1:0];
					wl_wr_data = cand_vert;
				end
			end
			ST_FINISH: begin
				emit      = out_free;
				emit_last = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= VERTEX_COUNT_RESET;
			directed_q     <= 1'b0;
			search_order_q <= ORDER_DFS;
			row_vld_q      <= '0;
			visited_q      <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_VERTEX_COUNT: vertex_count_q <= cfg_data;
					CFG_DIRECTED:     directed_q     <= cfg_data[0];
					CFG_SEARCH_ORDER: search_order_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (adj_wr_en) row_vld_q[adj_wr_addr] <= 1'b1;
			if (trav_start) begin
				visited_q <= start_ok ? bit_of(IW'(in_start - ONE_V)) : '0;
				head_q    <= '0;
				tail_q    <= start_ok ? ONE_V : '0;
			end else begin
				if (push) begin
					visited_q <= visited_q | bit_of(cand_idx);
					tail_q    <= tail_q + ONE_V;
				end else if (pop) begin
					tail_q <= tail_m1;
				end
				if (deq) head_q <= head_q + ONE_V;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			src_q <= in_src;
			dst_q <= in_dst;
		end
		if (trav_start) begin
			pend_q <= in_start;
		end else if (emit && !emit_last) begin
			pend_q <= (state_q == ST_BFS_ROW) ? wl_rd_s1 : cand_vert;
		end
		if (emit) begin
			out_item_q.vertex <= VERT_W'(pend_q);
			out_item_q.last   <= emit_last;
		end
	end

	// adjacency matrix, one write and one read port
	always_ff @(posedge clk) begin
		if (adj_wr_en) adj_mem[adj_wr_addr] <= adj_wr_data;
		if (adj_rd_en) begin
			adj_rd_s1  <= adj_mem[adj_rd_addr];
			adj_vld_s1 <= row_vld_q[adj_rd_addr];
		end
	end

	// stack or queue of vertices
	always_ff @(posedge clk) begin
		if (wl_wr_en) wl_mem[wl_wr_addr] <= wl_wr_data;
		if (wl_rd_en) wl_rd_s1 <= wl_mem[wl_rd_addr];
	end

	`GTA_ASSERT_SAME(a_tail_bound, state_q == ST_DFS_PICK || state_q == ST_BFS_SCAN, tail_q <= lim)
	`GTA_ASSERT_SAME(a_head_le_tail, state_q == ST_BFS_DEQ || state_q == ST_BFS_SCAN, head_q <= tail_q)
	`GTA_ASSERT_NEXT(a_push_marks, push, $countones(visited_q) == $countones($past(visited_q)) + 1)
	`GTA_ASSERT_NEXT(a_finish_last, state_q == ST_FINISH && out_free, out_valid_q && out_item_q.last)

endmodule

// File: dv/gta_visit_checker.sv
`timescale 1ns / 1ps
module gta_visit_checker #(
	parameter int NV = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  gta_pkg::gta_in_t              in_item,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  gta_pkg::gta_out_t             out_item,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [gta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gta_pkg::VERT_W-1:0]    cfg_data,
	output int                            mismatches,
	output int                            visits_due,
	output int                            visits_checked
);
	import gta_pkg::*;

	logic [VERT_W-1:0] vcount;
	logic              dir_mode;
	logic              order_mode;
	logic [NV:0]       adj [0:NV];
	gta_out_t          expected_visits[$];

	always @(posedge clk or negedge arst_n) begin
		logic [NV:0] seen;
		int          work [0:NV];
		int          order[$];
		int          lim, head, tail, v, w, s, d;
		gta_out_t    exp_v;
		if (!arst_n) begin
			vcount = VERTEX_COUNT_RESET;
			dir_mode = 1'b0;
			order_mode = ORDER_DFS;
			foreach (adj[r]) adj[r] = '0;
			expected_visits.delete();
			mismatches = 0;
			visits_checked = 0;
			visits_due = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_visits.size() == 0) begin
					$display("%0t: unexpected vertex %0d last %0b, expected none", $time,
						out_item.vertex, out_item.last);
					mismatches++;
				end else begin
					exp_v = expected_visits.pop_front();
					if (out_item.vertex !== exp_v.vertex) begin
						$display("%0t: vertex mismatch, expected %0d, actual %0d", $time,
							exp_v.vertex, out_item.vertex);
						mismatches++;
					end
					if (out_item.last !== exp_v.last) begin
						$display("%0t: last flag mismatch at vertex %0d, expected %0b, actual %0b",
							$time, exp_v.vertex, exp_v.last, out_item.last);
						mismatches++;
					end
					visits_checked++;
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VERTEX_COUNT: vcount = cfg_data;
					CFG_DIRECTED:     dir_mode = cfg_data[0];
					CFG_SEARCH_ORDER: order_mode = cfg_data[0];
					default: ;
				endcase
			end

			lim = (vcount > NV) ? NV : int'(vcount);
			if (in_valid && !in_stall) begin
				if (in_item.req_type == REQ_EDGE) begin
					s = int'(in_item.src_vertex);
					d = int'(in_item.dst_vertex);
					if (s != 0 && d != 0 && s <= lim && d <= lim && s != d) begin
						adj[s][d] = 1'b1;
						if (!dir_mode)
							adj[d][s] = 1'b1;
					end
				end else begin
					s = int'(in_item.start_vertex);
					order.delete();
					if (s != 0 && s <= lim) begin
						seen = '0;
						seen[s] = 1'b1;
						work[0] = s;
						head = 0;
						tail = 1;
						if (order_mode == ORDER_DFS) begin
							// stack walk, lowest unvisited neighbour of the top first
							order.push_back(s);
							while (tail > 0) begin
								v = work[tail-1];
								w = 0;
								for (int i = lim; i >= 1; i--)
									if (!seen[i] && adj[v][i])
										w = i;
								if (w == 0) begin
									tail--;
								end else begin
									seen[w] = 1'b1;
									order.push_back(w);
									work[tail] = w;
									tail++;
								end
							end
						end else begin
							// queue walk, vertices come out in queue order
							while (head < tail) begin
								v = work[head];
								head++;
								order.push_back(v);
								for (int i = 1; i <= lim; i++) begin
									if (!seen[i] && adj[v][i]) begin
										seen[i] = 1'b1;
										work[tail] = i;
										tail++;
									end
								end
							end
						end
					end
					foreach (order[k]) begin
						exp_v.vertex = VERT_W'(order[k]);
						exp_v.last = (k == order.size() - 1);
						expected_visits.push_back(exp_v);
					end
				end
			end
			visits_due = expected_visits.size();
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import gta_pkg::*;

	localparam int NV            = 64;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	gta_in_t              in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	gta_out_t             out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VERT_W-1:0]    cfg_data = '0;

	int   mismatches, visits_due, visits_checked;
	int   send_idle_pct = 13;
	int   recv_idle_pct = 85;
	logic hold_now = 1'b0;
	logic hold_done = 1'b0;
	int   quiet = 0;
	int   n_edges = 0;
	int   n_walks = 0;
	int   n_cfg = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	graph_traversal_adjacency #(.MAX_VERTICES(NV)) dut (.*);

	gta_visit_checker #(.NV(NV)) visit_check (.*);

	initial begin
		forever begin
			@(posedge clk);
			if (hold_now && !hold_done) begin
				// long hold-off so the walk backs up into the input
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("graph_traversal_adjacency regression: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [VERT_W-1:0] flag_val(logic b);
		return {(VERT_W-1)'($urandom_range(0, 63)), b};
	endfunction

	function automatic gta_in_t edge_req(int s, int d);
		gta_in_t r;
		r.req_type = REQ_EDGE;
		r.src_vertex = VERT_W'(s);
		r.dst_vertex = VERT_W'(d);
		r.start_vertex = VERT_W'($urandom_range(0, 127));
		return r;
	endfunction

	function automatic gta_in_t walk_req(int v);
		gta_in_t r;
		r.req_type = REQ_TRAVERSE;
		r.src_vertex = VERT_W'($urandom_range(0, 127));
		r.dst_vertex = VERT_W'($urandom_range(0, 127));
		r.start_vertex = VERT_W'(v);
		return r;
	endfunction

	function automatic logic [VERT_W-1:0] pick_vertex(int lim);
		if (lim == 0 || $urandom_range(0, 99) < 8)
			return VERT_W'($urandom_range(0, 127));
		return VERT_W'($urandom_range(1, lim));
	endfunction

	function automatic gta_in_t random_req(int lim);
		gta_in_t r;
		r.req_type = ($urandom_range(0, 99) < 65) ? REQ_EDGE : REQ_TRAVERSE;
		r.src_vertex = pick_vertex(lim);
		r.dst_vertex = pick_vertex(lim);
		r.start_vertex = pick_vertex(lim);
		return r;
	endfunction

	task automatic send_req(input gta_in_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (r.req_type == REQ_EDGE)
			n_edges++;
		else
			n_walks++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (visits_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VERT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_cfg++;
	endtask

	initial begin
		int cnt, lim;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_VERTEX_COUNT, 7'd64);
		write_reg(CFG_DIRECTED, flag_val(1'b0));
		write_reg(CFG_SEARCH_ORDER, flag_val(ORDER_DFS));
		send_req(edge_req(1, 2));
		send_req(edge_req(2, 3));
		send_req(edge_req(1, 64));
		send_req(edge_req(64, 5));
		send_req(edge_req(5, 5));
		send_req(edge_req(0, 7));
		send_req(edge_req(7, 0));
		send_req(edge_req(65, 3));
		send_req(edge_req(3, 127));
		send_req(walk_req(1));
		send_req(walk_req(0));
		send_req(walk_req(65));
		send_req(walk_req(127));
		send_req(walk_req(40));

		settle();
		write_reg(CFG_SEARCH_ORDER, flag_val(ORDER_BFS));
		send_req(walk_req(1));
		send_req(walk_req(64));

		// directed mode keeps the undirected edges already stored
		settle();
		write_reg(CFG_DIRECTED, flag_val(1'b1));
		send_req(edge_req(10, 11));
		send_req(walk_req(11));
		send_req(walk_req(10));

		// stale edges beyond the vertex count are not followed
		settle();
		write_reg(CFG_VERTEX_COUNT, 7'd3);
		send_req(walk_req(1));
		send_req(edge_req(1, 4));

		settle();
		write_reg(CFG_VERTEX_COUNT, 7'd0);
		send_req(edge_req(1, 2));
		send_req(walk_req(1));

		settle();
		write_reg(CFG_VERTEX_COUNT, 7'd1);
		send_req(walk_req(1));

		settle();
		write_reg(CFG_VERTEX_COUNT, 7'd127);
		write_reg(CFG_SPARE, 7'h55);
		send_req(walk_req(2));

		for (int p = 0; p < 6; p++) begin
			settle();
			if (p == 2) begin
				send_idle_pct = 85;
				recv_idle_pct = 13;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: cnt = 64;
				1: cnt = $urandom_range(2, 16);
				2: cnt = 127;
				3: cnt = $urandom_range(2, 64);
				4: cnt = 64;
				default: cnt = $urandom_range(8, 32);
			endcase
			lim = (cnt > NV) ? NV : cnt;
			write_reg(CFG_VERTEX_COUNT, VERT_W'(cnt));
			write_reg(CFG_DIRECTED, flag_val(p[0]));
			write_reg(CFG_SEARCH_ORDER, flag_val(p[1] ^ p[2]));
			if (p == 4)
				hold_now <= 1'b1;
			for (int k = 0; k < 64; k++)
				send_req(random_req(lim));
		end

		settle();
		$display("covered %0d edge and %0d traversal requests with %0d register writes,",
			n_edges, n_walks, n_cfg);
		$display("depth and breadth first, directed and undirected; %0d vertices checked",
			visits_checked);
		if (mismatches == 0 && visits_due == 0) begin
			$display("graph_traversal_adjacency regression: pass");
		end else begin
			$display("graph_traversal_adjacency regression: fail");
		end
		$finish;
	end

endmodule

// File: graph_traversal_adjacency.f
+incdir+design
design/gta_pkg.sv
design/graph_traversal_adjacency.sv
dv/gta_visit_checker.sv
dv/tb.sv
